// ===== rtl/core/ntd_pkg.sv =====
package ntd_pkg;

    // Reset value of the output limit register.
    localparam logic [15:0] LIMIT_RESET = 16'd1023;

    // Nibble that opens an escape sequence.
    localparam logic [3:0] NIB_ESC = 4'hF;

    // Character produced by a space run.
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    // Most results that one transaction can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Escape progress, one-hot.
    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_LOW  = 3'b010,
        ESC_HIGH = 3'b100
    } esc_phase_t;

    // Per-stream decoding state.
    typedef struct packed {
        esc_phase_t  phase;
        logic [3:0]  held;
        logic [15:0] count;
        logic        halted;
    } stream_t;

    localparam stream_t STREAM_CLEAR = '{
        phase:  ESC_NONE,
        held:   4'd0,
        count:  16'd0,
        halted: 1'b0
    };

    // One result item.
    typedef struct packed {
        logic [6:0]  char_code;
        logic [6:0]  repeat_count;
        logic        end_of_stream;
        logic        incomplete_escape;
        logic [15:0] total_length;
    } result_t;

    // Results of one transaction, packed towards entry zero.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                num;
    } res_batch_t;

    // Status of the result buffer as seen by the input side.
    typedef struct packed {
        logic       free;
        logic [1:0] pending;
    } buf_status_t;

    // Outcome of decoding a single nibble.
    typedef struct packed {
        stream_t st;
        logic    hit;
        result_t res;
    } step_t;

    // Character for a plain nibble.
    function automatic logic [6:0] ntd_char(input logic [3:0] nib);
        logic [6:0] ch;
        case (nib)
            4'h0, 4'h1, 4'h2, 4'h3, 4'h4,
            4'h5, 4'h6, 4'h7, 4'h8, 4'h9: ch = 7'h30 + {3'd0, nib};
            4'hA:    ch = CHAR_SPACE;
            4'hB:    ch = 7'h3A;
            4'hC:    ch = 7'h2F;
            4'hD:    ch = 7'h0D;
            4'hE:    ch = 7'h0A;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // Decodes one nibble against the current stream state.
    function automatic step_t ntd_feed(input stream_t st, input logic [3:0] nib,
                                       input logic [15:0] limit);
        step_t       s;
        logic [15:0] room;
        logic [7:0]  value;
        logic [6:0]  run;
        s       = '0;
        s.st    = st;
        room    = (st.count < limit) ? (limit - st.count) : 16'd0;
        value   = {nib, st.held};
        run     = value[6:0];
        if (room < {9'd0, run})
        begin
            run = room[6:0];
        end
        case (st.phase)
            ESC_NONE:
            begin
                if (st.halted || (st.count >= limit))
                begin
                    s.st.halted = 1'b1;
                end
                else if (nib == NIB_ESC)
                begin
                    s.st.phase = ESC_LOW;
                end
                else
                begin
                    s.st.count            = st.count + 16'd1;
                    s.hit                 = 1'b1;
                    s.res.char_code       = ntd_char(nib);
                    s.res.repeat_count    = 7'd1;
                    s.res.total_length    = st.count + 16'd1;
                end
            end
            ESC_LOW:
            begin
                s.st.held  = nib;
                s.st.phase = ESC_HIGH;
            end
            ESC_HIGH:
            begin
                s.st.phase = ESC_NONE;
                s.st.held  = 4'd0;
                if (value[7])
                begin
                    // Space run, clamped to the room that is left.
                    if (run != 7'd0)
                    begin
                        s.st.count         = st.count + {9'd0, run};
                        s.hit              = 1'b1;
                        s.res.char_code    = CHAR_SPACE;
                        s.res.repeat_count = run;
                        s.res.total_length = st.count + {9'd0, run};
                    end
                end
                else if (room != 16'd0)
                begin
                    s.st.count         = st.count + 16'd1;
                    s.hit              = 1'b1;
                    s.res.char_code    = value[6:0];
                    s.res.repeat_count = 7'd1;
                    s.res.total_length = st.count + 16'd1;
                end
            end
            default:
            begin
                s.st.phase = ESC_NONE;
                s.st.held  = 4'd0;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/ntd_decoder.sv =====
module ntd_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [15:0]         limit,
    output ntd_pkg::res_batch_t batch
);
    import ntd_pkg::*;

    stream_t st_reg;
    stream_t st_next;
    step_t   step_low;
    step_t   step_high;
    logic    skip_high;
    logic [1:0] idx;

    // Decode both nibbles of the held byte and gather the results in order.
    always_comb
    begin
        step_low  = ntd_feed(st_reg, data_byte[3:0], limit);
        skip_high = last_byte && (data_byte[7:4] == NIB_ESC);
        if (skip_high)
        begin
            step_high     = '0;
            step_high.st  = step_low.st;
        end
        else
        begin
            step_high = ntd_feed(step_low.st, data_byte[7:4], limit);
        end

        batch = '0;
        idx   = 2'd0;
        if (step_low.hit)
        begin
            batch.res[idx] = step_low.res;
            idx            = idx + 2'd1;
        end
        if (step_high.hit)
        begin
            batch.res[idx] = step_high.res;
            idx            = idx + 2'd1;
        end
        if (last_byte)
        begin
            batch.res[idx].end_of_stream     = 1'b1;
            batch.res[idx].incomplete_escape = (step_high.st.phase != ESC_NONE);
            batch.res[idx].total_length      = step_high.st.count;
            idx                              = idx + 2'd1;
        end
        batch.num = idx;

        st_next = last_byte ? STREAM_CLEAR : step_high.st;
    end

    // Stream state advances once per decoded transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STREAM_CLEAR;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== rtl/core/ntd_result_buffer.sv =====
module ntd_result_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ntd_pkg::res_batch_t  batch,
    input  logic                 out_stall,
    output logic                 out_valid,
    output ntd_pkg::result_t     head,
    output ntd_pkg::buf_status_t status
);
    import ntd_pkg::*;

    result_t [MAX_RESULTS-1:0] entry_reg;
    logic [1:0]                pend_reg;
    logic [1:0]                rd_reg;
    logic                      take;

    // Hand results out one per transaction on the output channel.
    always_comb
    begin
        out_valid      = (pend_reg != 2'd0);
        take           = out_valid && !out_stall;
        status.pending = pend_reg;
        status.free    = (pend_reg == 2'd0) || ((pend_reg == 2'd1) && take);
        case (rd_reg)
            2'd0:    head = entry_reg[0];
            2'd1:    head = entry_reg[1];
            2'd2:    head = entry_reg[2];
            default: head = entry_reg[0];
        endcase
    end

    // Result entries carry no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= batch.res;
        end
    end

    // Pending count and read index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            rd_reg   <= 2'd0;
        end
        else if (load)
        begin
            pend_reg <= batch.num;
            rd_reg   <= 2'd0;
        end
        else if (take)
        begin
            pend_reg <= pend_reg - 2'd1;
            rd_reg   <= rd_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/core/nibble_text_decompressor.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  data_byte, last_byte
// out       output     out_valid / out_stall char_code, repeat_count, end_of_stream,
//                                           incomplete_escape, total_length
// cfg       input      cfg_valid / cfg_ready output_limit
//
// A byte is registered on input and decoded in one pass once the result buffer can take its
// results, which go into a three-entry result buffer; the first result is offered in the cycle
// after the transaction. One byte is taken per cycle while each byte yields at most one result
// and the output is not stalled; a byte with more results holds the output for each of them.
// Reset clears the stream state and sets the limit to 1023; a held byte waits until the
// buffer's last result is taken.
module nibble_text_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  char_code,
    output logic [6:0]  repeat_count,
    output logic        end_of_stream,
    output logic        incomplete_escape,
    output logic [15:0] total_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] output_limit
);
    import ntd_pkg::*;

    logic        in_full_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [15:0] limit_reg;
    logic        fire;
    logic        in_take;
    res_batch_t  batch;
    result_t     head;
    buf_status_t buf_st;

    // The held byte is decoded once the result buffer can take its results.
    assign fire      = in_full_reg && buf_st.free;
    assign in_stall  = in_full_reg && !buf_st.free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= output_limit;
        end
    end

    // Input register occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    ntd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_reg),
        .last_byte (last_reg),
        .limit     (limit_reg),
        .batch     (batch)
    );

    ntd_result_buffer u_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .batch     (batch),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .status    (buf_st)
    );

    // Result fields onto the output ports.
    assign char_code         = head.char_code;
    assign repeat_count      = head.repeat_count;
    assign end_of_stream     = head.end_of_stream;
    assign incomplete_escape = head.incomplete_escape;
    assign total_length      = head.total_length;

`ifndef NO_ASSERTIONS
    // A byte held back by a busy buffer stays in the input register unchanged.
    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !buf_st.free |=> in_full_reg && $stable(data_reg)
            && $stable(last_reg))
        else $error("held input byte lost or changed");

    // The final byte of a stream always produces its closing result.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_reg |-> batch.num != 2'd0)
        else $error("final byte decoded without a closing result");

    // A closing result carries no character.
    a_close_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_stream |-> char_code == 7'd0 && repeat_count == 7'd0)
        else $error("closing result carries a character");

    // After a decode the buffer holds exactly the results of that byte.
    a_pending_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> buf_st.pending == $past(batch.num))
        else $error("result buffer count does not match decoded results");
`endif

endmodule
